// ----- design/srtf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// srtf_pkg
// Types and constants shared by the SRTF scheduler modules.
// ============================================================================
package srtf_pkg;

    localparam int MAX_JOBS = 16;
    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;
    localparam int BURST_W  = 16;
    localparam int SUM_W    = 48;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic FUNC_ADMIT = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [ID_W-1:0]    job_id;
        logic [TIME_W-1:0]  arrival_time;
        logic [BURST_W-1:0] burst_time;
    } t_req;

    typedef struct packed {
        logic [TIME_W-1:0]  now;
        logic               admit_refused;
        logic               idle;
        logic [ID_W-1:0]    running_id;
        logic [BURST_W-1:0] remaining_left;
        logic               finished;
        logic [TIME_W-1:0]  finish_time;
        logic [TIME_W-1:0]  turnaround;
        logic [TIME_W-1:0]  waiting;
        logic [SUM_W-1:0]   sum_waiting;
        logic [SUM_W-1:0]   sum_turnaround;
    } t_result;

    // One job entry held by a chain cell
    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    job;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] rem;
    } t_slot;

    typedef struct packed {
        logic ins;   // sorted insert of a new job
        logic pop;   // head finished, shift toward head
        logic dec;   // decrement own remaining time
    } t_cell_ctl;

    typedef struct packed {
        logic calc;  // compute finish, turnaround, waiting
        logic sum;   // add to running totals
    } t_acct_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SUM
    } t_state;

endpackage : srtf_pkg
`default_nettype wire

// ----- design/srtf_scheduler.sv -----
// A request is taken only in ST_IDLE and captured; ST_CALC then does the accounting
//   and ST_SUM updates the totals and loads the result, waiting while an old one stalls;
//   the result register lets the next request enter while a result waits.
// The job table is a chain of MAX_JOBS cells kept sorted, so the head is the pick.
// Reset (synchronous, active low) empties the chain and clears time counter,
//   totals and control state at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// srtf_scheduler
// Preemptive shortest-remaining-time-first scheduler with a sorted job chain.
// ============================================================================
module srtf_scheduler
    import srtf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_req    i_req,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_result      o_result
);

    t_state    r_state;
    t_state    n_state;
    t_slot     w_slot [MAX_JOBS];
    logic      w_gt   [MAX_JOBS];
    t_cell_ctl w_ctl  [MAX_JOBS];
    t_slot     w_new;
    t_slot     w_head;
    t_acct_ctl w_acct_ctl;

    logic w_accept;
    logic w_admit;
    logic w_tick;
    logic w_full;
    logic w_ins;
    logic w_pop;
    logic w_dec;
    logic w_calc;
    logic w_load;

    logic [TIME_W-1:0]  r_time;
    logic [TIME_W-1:0]  r_now;
    logic               r_refused;
    logic               r_idle;
    logic [ID_W-1:0]    r_id;
    logic [BURST_W-1:0] r_left;
    logic               r_fin_flag;
    logic [TIME_W-1:0]  r_arr;
    logic [BURST_W-1:0] r_burst;
    logic               r_out_valid;
    t_result            r_out;

    logic [TIME_W-1:0]  w_fin;
    logic [TIME_W-1:0]  w_tat;
    logic [TIME_W-1:0]  w_wt;
    logic [SUM_W-1:0]   w_wsum;
    logic [SUM_W-1:0]   w_tsum;

    assign w_head   = w_slot[0];
    assign w_full   = w_slot[MAX_JOBS-1].valid;
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_admit  = w_accept && (i_req.func == FUNC_ADMIT);
    assign w_tick   = w_accept && (i_req.func == FUNC_TICK);
    assign w_ins    = w_admit && !w_full;
    // head with at most one tick left finishes now
    assign w_pop    = w_tick && w_head.valid && (w_head.rem <= BURST_W'(1));
    assign w_dec    = w_tick && w_head.valid && (w_head.rem > BURST_W'(1));

    always_comb begin
        w_new.valid   = 1'b1;
        w_new.job     = i_req.job_id;
        w_new.arrival = i_req.arrival_time;
        w_new.burst   = i_req.burst_time;
        w_new.rem     = i_req.burst_time;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_JOBS; g++) begin : g_cell
            t_slot w_left;
            t_slot w_right;
            logic  w_lgt;

            if (g == 0) begin : g_first
                assign w_left = '0;
                assign w_lgt  = 1'b0;
            end else begin : g_mid
                assign w_left = w_slot[g-1];
                assign w_lgt  = w_gt[g-1];
            end

            if (g == MAX_JOBS-1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_slot[g+1];
            end

            assign w_ctl[g].ins = w_ins;
            assign w_ctl[g].pop = w_pop;
            assign w_ctl[g].dec = (g == 0) ? w_dec : 1'b0;

            srtf_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl[g]),
                .i_left    (w_left),
                .i_left_gt (w_lgt),
                .i_right   (w_right),
                .i_new     (w_new),
                .o_slot    (w_slot[g]),
                .o_gt      (w_gt[g])
            );
        end
    endgenerate

    // Capture what the request saw of the chain head
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now      <= r_time;
            r_refused  <= w_admit && w_full;
            r_idle     <= w_tick && !w_head.valid;
            r_id       <= (w_tick && w_head.valid) ? w_head.job : '0;
            r_left     <= (w_dec) ? (w_head.rem - BURST_W'(1)) : '0;
            r_fin_flag <= w_pop;
            r_arr      <= w_head.arrival;
            r_burst    <= w_head.burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (w_tick) begin
            r_time <= r_time + TIME_W'(1);
        end
    end

    assign w_acct_ctl.calc = w_calc;
    assign w_acct_ctl.sum  = w_load && r_fin_flag;

    srtf_acct u_acct (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (w_acct_ctl),
        .i_now              (r_now),
        .i_arrival          (r_arr),
        .i_burst            (r_burst),
        .o_finish_time      (w_fin),
        .o_turnaround       (w_tat),
        .o_waiting          (w_wt),
        .o_total_waiting    (w_wsum),
        .o_total_turnaround (w_tsum)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_calc     = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_CALC: begin
                w_calc = 1'b1;
            end
            ST_SUM: begin
                w_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.now            <= r_now;
            r_out.admit_refused  <= r_refused;
            r_out.idle           <= r_idle;
            r_out.running_id     <= r_id;
            r_out.remaining_left <= r_left;
            r_out.finished       <= r_fin_flag;
            r_out.finish_time    <= r_fin_flag ? w_fin : '0;
            r_out.turnaround     <= r_fin_flag ? w_tat : '0;
            r_out.waiting        <= r_fin_flag ? w_wt : '0;
            r_out.sum_waiting    <= w_wsum;
            r_out.sum_turnaround <= w_tsum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

`ifndef NO_ASSERTIONS
    logic [MAX_JOBS-2:0] w_sorted;

    always_comb begin
        for (int k = 0; k < MAX_JOBS-1; k++) begin
            w_sorted[k] = !w_slot[k+1].valid ||
                          (w_slot[k].valid && (w_slot[k].rem <= w_slot[k+1].rem));
        end
    end

    a_chain_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_sorted)
        else $error("job chain lost its order or has a gap");

    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_admit && !w_full) |=> !r_refused)
        else $error("admit refused with a free cell");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick && w_head.valid) |=> (!r_idle && (r_state == ST_CALC)))
        else $error("tick with a waiting job reported idle");
`endif

endmodule : srtf_scheduler
`default_nettype wire

// ----- design/srtf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// srtf_cell
// One cell of the sorted job chain. Cells stay ordered by remaining time,
// ties by admission order; the head cell always holds the next job to run.
// ============================================================================
module srtf_cell
    import srtf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_slot     i_left,
    input  wire logic      i_left_gt,
    input  wire t_slot     i_right,
    input  wire t_slot     i_new,
    output t_slot          o_slot,
    output logic           o_gt
);

    t_slot r_slot;
    t_slot n_slot;

    // New job goes behind every job with remaining time <= its burst
    assign o_gt = !r_slot.valid || (r_slot.rem > i_new.rem);

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.ins && o_gt) begin
            n_slot = i_left_gt ? i_left : i_new;
        end else if (i_ctl.pop) begin
            n_slot = i_right;
        end else if (i_ctl.dec && (r_slot.rem != '0)) begin
            n_slot.rem = r_slot.rem - BURST_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule : srtf_cell
`default_nettype wire

// ----- design/srtf_acct.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// srtf_acct
// Completion accounting: finish, turnaround and waiting times and the
// saturating running totals.
// ============================================================================
module srtf_acct
    import srtf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_acct_ctl          i_ctl,
    input  wire logic [TIME_W-1:0]  i_now,
    input  wire logic [TIME_W-1:0]  i_arrival,
    input  wire logic [BURST_W-1:0] i_burst,
    output logic [TIME_W-1:0]       o_finish_time,
    output logic [TIME_W-1:0]       o_turnaround,
    output logic [TIME_W-1:0]       o_waiting,
    output logic [SUM_W-1:0]        o_total_waiting,
    output logic [SUM_W-1:0]        o_total_turnaround
);

    logic [TIME_W-1:0] r_fin;
    logic [TIME_W-1:0] r_tat;
    logic [TIME_W-1:0] r_wt;
    logic [SUM_W-1:0]  r_wsum;
    logic [SUM_W-1:0]  r_tsum;
    logic [SUM_W-1:0]  n_wsum;
    logic [SUM_W-1:0]  n_tsum;
    logic [SUM_W:0]    w_wadd;
    logic [SUM_W:0]    w_tadd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.calc) begin
            r_fin <= i_now + TIME_W'(1);
            r_tat <= i_now + TIME_W'(1) - i_arrival;
            r_wt  <= i_now + TIME_W'(1) - i_arrival - TIME_W'(i_burst);
        end
    end

    always_comb begin
        w_wadd = {1'b0, r_wsum} + (SUM_W+1)'(r_wt);
        w_tadd = {1'b0, r_tsum} + (SUM_W+1)'(r_tat);
        n_wsum = r_wsum;
        n_tsum = r_tsum;
        if (i_ctl.sum) begin
            n_wsum = w_wadd[SUM_W] ? SUM_MAX : w_wadd[SUM_W-1:0];
            n_tsum = w_tadd[SUM_W] ? SUM_MAX : w_tadd[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum <= '0;
            r_tsum <= '0;
        end else begin
            r_wsum <= n_wsum;
            r_tsum <= n_tsum;
        end
    end

    assign o_finish_time      = r_fin;
    assign o_turnaround       = r_tat;
    assign o_waiting          = r_wt;
    assign o_total_waiting    = n_wsum;
    assign o_total_turnaround = n_tsum;

endmodule : srtf_acct
`default_nettype wire
